[rtl/kmdg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdg_pkg
// Shared types, constants and key tables of the key matrix scanner.
// ----------------------------------------------------------------------------
package kmdg_pkg;

  localparam int unsigned DefMatrixRows  = 8;
  localparam int unsigned DefMatrixCols  = 8;
  localparam int unsigned DefReportSlots = 6;

  localparam int unsigned KeyCount   = 65;
  localparam int unsigned RestoreKey = 64;
  localparam int unsigned KeyIdxW    = 7;
  localparam int unsigned OutSlots   = 6;

  localparam logic [7:0] GhostTicksRst    = 8'd10;
  localparam logic [7:0] DebounceTicksRst = 8'd25;

  localparam logic [7:0] ModShift  = 8'h22;
  localparam logic [7:0] ModCtrl   = 8'h11;
  localparam logic [7:0] ModLshift = 8'h02;

  localparam logic [7:0] CodeFirstReal = 8'h04;
  localparam logic [7:0] CodeRollover  = 8'h01;

  // register indexes on the configuration port
  localparam logic RegGhostTicks    = 1'b0;
  localparam logic RegDebounceTicks = 1'b1;

  typedef enum logic [2:0] {
    OP_SAMPLE,
    OP_RESTORE,
    OP_GHOST,
    OP_CHECK,
    OP_REPORT
  } kmdg_op_e;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] deb;
    logic       sent;
    logic [7:0] capmod;
  } kmdg_key_t;

  localparam int unsigned KeyWordW = $bits(kmdg_key_t);

  typedef struct packed {
    logic               scan_start;
    logic               rpt_start;
    logic               issue;
    kmdg_op_e           op;
    logic [KeyIdxW-1:0] idx;
    logic               cmp_step;
    logic               load;
  } kmdg_cmd_t;

  typedef struct packed {
    logic               cmp_done;
    logic               cmp_need_rd;
    logic [KeyIdxW-1:0] cmp_ix;
    logic               out_free;
  } kmdg_sts_t;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] modb;
  } kmdg_xlat_t;

  function automatic logic [7:0] kmdg_hid_code(input logic [KeyIdxW-1:0] k);
    logic [7:0] c;
    case (k)
      7'd0:  c = 8'h1E; 7'd1:  c = 8'h2A; 7'd2:  c = 8'hE0; 7'd3:  c = 8'h48;
      7'd4:  c = 8'h2C; 7'd5:  c = 8'hE2; 7'd6:  c = 8'h14; 7'd7:  c = 8'h1F;
      7'd8:  c = 8'h20; 7'd9:  c = 8'h1A; 7'd10: c = 8'h04; 7'd11: c = 8'hE1;
      7'd12: c = 8'h1D; 7'd13: c = 8'h16; 7'd14: c = 8'h08; 7'd15: c = 8'h21;
      7'd16: c = 8'h22; 7'd17: c = 8'h15; 7'd18: c = 8'h07; 7'd19: c = 8'h1B;
      7'd20: c = 8'h06; 7'd21: c = 8'h09; 7'd22: c = 8'h17; 7'd23: c = 8'h23;
      7'd24: c = 8'h24; 7'd25: c = 8'h1C; 7'd26: c = 8'h0A; 7'd27: c = 8'h19;
      7'd28: c = 8'h05; 7'd29: c = 8'h0B; 7'd30: c = 8'h18; 7'd31: c = 8'h25;
      7'd32: c = 8'h26; 7'd33: c = 8'h0C; 7'd34: c = 8'h0D; 7'd35: c = 8'h11;
      7'd36: c = 8'h10; 7'd37: c = 8'h0E; 7'd38: c = 8'h12; 7'd39: c = 8'h27;
      7'd40: c = 8'h2E; 7'd41: c = 8'h13; 7'd42: c = 8'h0F; 7'd43: c = 8'h36;
      7'd44: c = 8'h37; 7'd45: c = 8'h33; 7'd46: c = 8'h2F; 7'd47: c = 8'h2D;
      7'd48: c = 8'h35; 7'd49: c = 8'h30; 7'd50: c = 8'h34; 7'd51: c = 8'h38;
      7'd52: c = 8'hE5; 7'd53: c = 8'h4E; 7'd54: c = 8'h4B; 7'd55: c = 8'h4A;
      7'd56: c = 8'h4C; 7'd57: c = 8'h28; 7'd58: c = 8'h4F; 7'd59: c = 8'h51;
      7'd60: c = 8'h3A; 7'd61: c = 8'h3C; 7'd62: c = 8'h3E; 7'd63: c = 8'h40;
      7'd64: c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kmdg_key_mod(input logic [KeyIdxW-1:0] k);
    logic [7:0] c;
    logic [7:0] m;
    c = kmdg_hid_code(k);
    m = 8'h00;
    if (c[7:3] == 5'b11100) m = 8'h01 << c[2:0];
    return m;
  endfunction

  function automatic kmdg_xlat_t kmdg_translate(input logic [KeyIdxW-1:0] k,
                                                input logic [7:0] m_in);
    kmdg_xlat_t x;
    logic [7:0] m;
    logic [7:0] code;
    code = kmdg_hid_code(k);
    m    = m_in;
    if ((m & ModShift) != 8'h00) begin
      case (k)
        7'd1:  begin m = m & ~ModShift; code = 8'h29; end
        7'd7:  code = 8'h34;
        7'd23: code = 8'h24;
        7'd24: begin m = m & ~ModShift; code = 8'h34; end
        7'd31: code = 8'h26;
        7'd32: code = 8'h27;
        7'd39: begin m = m & ~ModShift; code = 8'h45; end
        7'd40: begin m = m & ~ModShift; code = 8'h4B; end
        7'd47: begin m = m & ~ModShift; code = 8'h4E; end
        7'd45: begin m = m & ~ModShift; code = 8'h2F; end
        7'd48: code = 8'h2D;
        7'd50: begin m = m & ~ModShift; code = 8'h30; end
        7'd54: code = 8'h35;
        7'd55: begin m = m & ~ModShift; code = 8'h4D; end
        7'd56: begin m = m & ~ModShift; code = 8'h49; end
        7'd58: begin m = m & ~ModShift; code = 8'h50; end
        7'd59: begin m = m & ~ModShift; code = 8'h52; end
        7'd60: begin m = m & ~ModShift; code = 8'h3B; end
        7'd61: begin m = m & ~ModShift; code = 8'h3D; end
        7'd62: begin m = m & ~ModShift; code = 8'h3F; end
        7'd63: begin m = m & ~ModShift; code = 8'h41; end
        default: ;
      endcase
    end else begin
      case (k)
        7'd40: m = m | ModLshift;
        7'd45: begin m = m | ModLshift; code = 8'h33; end
        7'd46: begin m = m | ModLshift; code = 8'h1F; end
        7'd49: begin m = m | ModLshift; code = 8'h25; end
        7'd50: code = 8'h33;
        7'd54: begin m = m | ModLshift; code = 8'h23; end
        default: ;
      endcase
    end
    if (((m & ModCtrl) != 8'h00) && (k == 7'd45 || k == 7'd46)) begin
      m    = m & ~ModShift;
      code = 8'h2F;
    end
    if (k == 7'd53) begin
      code = 8'h2E;
      m    = m & ~ModShift;
    end
    x.code = code;
    x.modb = m;
    return x;
  endfunction

endpackage

[rtl/kmdg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdg_if
// Scan/report request channel and HID report channel.
// ----------------------------------------------------------------------------
interface kmdg_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] matrix_open;
  logic        restore_open;

  modport source (output valid, action, matrix_open, restore_open, input ready);
  modport sink (input valid, action, matrix_open, restore_open, output ready);
endinterface

interface kmdg_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] key_slot_0;
  logic [7:0] key_slot_1;
  logic [7:0] key_slot_2;
  logic [7:0] key_slot_3;
  logic [7:0] key_slot_4;
  logic [7:0] key_slot_5;

  modport source (output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                  key_slot_3, key_slot_4, key_slot_5, input ready);
  modport sink (input valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                key_slot_3, key_slot_4, key_slot_5, output ready);
endinterface

[rtl/kmdg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kmdg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/kmdg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdg_ctrl
// Sequencer: walks the key state RAM for scan and report beats.
// ----------------------------------------------------------------------------
module kmdg_ctrl
  import kmdg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_action_i,
  output logic      in_ready_o,
  input  kmdg_sts_t sts_i,
  output kmdg_cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN1  = 3'd1;
  localparam logic [2:0] S_SCAN2  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_CMPW   = 3'd5;
  localparam logic [2:0] S_RPT    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  localparam logic [KeyIdxW-1:0] LastKey    = KeyIdxW'(RestoreKey);
  localparam logic [KeyIdxW-1:0] LastMatrix = KeyIdxW'(RestoreKey - 1);

  logic [2:0]         state_q, state_d;
  logic [KeyIdxW-1:0] idx_q, idx_d;
  logic               rdrain_q, rdrain_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    rdrain_d = rdrain_q;
    cmd_o    = '0;
    cmd_o.op = OP_SAMPLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          if (in_action_i) begin
            cmd_o.rpt_start = 1'b1;
            state_d = S_CMP;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN1;
          end
        end
      end
      S_SCAN1: begin
        cmd_o.issue = 1'b1;
        cmd_o.idx   = idx_q;
        if (idx_q == LastKey) begin
          cmd_o.op = OP_RESTORE;
          idx_d    = '0;
          state_d  = S_SCAN2;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN2: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_GHOST;
        cmd_o.idx   = idx_q;
        if (idx_q == LastMatrix) begin
          rdrain_d = 1'b0;
          state_d  = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        // last key of a walk is processed here
        state_d = rdrain_q ? S_FIN : S_IDLE;
      end
      S_CMP: begin
        if (sts_i.cmp_done) begin
          idx_d   = '0;
          state_d = S_RPT;
        end else if (sts_i.cmp_need_rd) begin
          cmd_o.issue = 1'b1;
          cmd_o.op    = OP_CHECK;
          cmd_o.idx   = sts_i.cmp_ix;
          state_d     = S_CMPW;
        end else begin
          cmd_o.cmp_step = 1'b1;
        end
      end
      S_CMPW: state_d = S_CMP;
      S_RPT: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_REPORT;
        cmd_o.idx   = idx_q;
        if (idx_q == LastKey) begin
          rdrain_d = 1'b1;
          state_d  = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      rdrain_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rdrain_q <= rdrain_d;
    end
  end
endmodule

[rtl/kmdg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdg_datapath
// Key state RAM, debounce/ghost update, slot queue and report register.
// ----------------------------------------------------------------------------
module kmdg_datapath
  import kmdg_pkg::*;
#(
  parameter int unsigned MATRIX_ROWS  = DefMatrixRows,
  parameter int unsigned MATRIX_COLS  = DefMatrixCols,
  parameter int unsigned REPORT_SLOTS = DefReportSlots
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kmdg_cmd_t                cmd_i,
  output kmdg_sts_t                sts_o,
  input  logic [63:0]              matrix_open_i,
  input  logic                     restore_open_i,
  input  logic [7:0]               ghost_ticks_i,
  input  logic [7:0]               debounce_ticks_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output logic [7:0]               rsp_mod_o,
  output logic [OutSlots-1:0][7:0] rsp_slot_o
);
  localparam int unsigned CW = $clog2(REPORT_SLOTS + 1);
  localparam int unsigned IW = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;

  // pipeline stage matching the registered RAM read
  logic               pipe_vld_q;
  kmdg_op_e           pipe_op_q;
  logic [KeyIdxW-1:0] pipe_idx_q;

  logic [KeyCount-1:0] kvalid_q;
  logic [KeyWordW-1:0] ram_rdata;
  logic                wr_en;
  kmdg_key_t           wr_key;

  logic [63:0] matrix_q;
  logic        restore_q;
  logic [7:0]  mod_q, mod_d;
  logic [1:0]  row_pop_q [8];
  logic [1:0]  row_pop_d [8];
  logic [1:0]  col_pop_q [8];
  logic [1:0]  col_pop_d [8];

  logic [CW-1:0]      count_q, count_d;
  logic [7:0]         slot_code_q [REPORT_SLOTS];
  logic [7:0]         slot_code_d [REPORT_SLOTS];
  logic [KeyIdxW-1:0] slot_ix_q [REPORT_SLOTS];
  logic [KeyIdxW-1:0] slot_ix_d [REPORT_SLOTS];
  logic [7:0]         sh_code [REPORT_SLOTS];
  logic [KeyIdxW-1:0] sh_ix [REPORT_SLOTS];
  logic               locked_q, locked_d;
  logic [7:0]         rm_q, rm_d;
  logic [7:0]         modsum_q, modsum_d;
  logic               ovf_q, ovf_d;

  logic                     rsp_valid_q, rsp_valid_d;
  logic [7:0]               rsp_mod_q, rsp_mod_d;
  logic [OutSlots-1:0][7:0] rsp_slot_q, rsp_slot_d;

  kmdg_key_t          rd_key, smp;
  logic [2:0]         row, col;
  logic               in_region, open_bit, cnt_full;
  logic [IW-1:0]      cidx;
  logic [7:0]         cur_code;
  logic [KeyIdxW-1:0] cur_ix;
  logic [7:0]         gstart, gclamp, km;
  kmdg_xlat_t         xl;

  kmdg_ram #(
    .WIDTH (KeyWordW),
    .DEPTH (KeyCount)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pipe_idx_q),
    .wdata_i (wr_key),
    .raddr_i (cmd_i.idx),
    .rdata_o (ram_rdata)
  );

  assign rd_key    = kvalid_q[pipe_idx_q] ? kmdg_key_t'(ram_rdata) : '0;
  assign row       = pipe_idx_q[5:3];
  assign col       = pipe_idx_q[2:0];
  assign in_region = ({1'b0, row} < 4'(MATRIX_ROWS)) && ({1'b0, col} < 4'(MATRIX_COLS))
                     && (pipe_idx_q != KeyIdxW'(RestoreKey));
  assign cnt_full  = (count_q >= CW'(REPORT_SLOTS));
  assign cidx      = cnt_full ? '0 : count_q[IW-1:0];
  assign cur_code  = slot_code_q[cidx];
  assign cur_ix    = slot_ix_q[cidx];
  assign km        = kmdg_key_mod(pipe_idx_q);
  assign xl        = kmdg_translate(pipe_idx_q, rd_key.capmod);

  always_comb begin
    gclamp = ghost_ticks_i;
    if (gclamp == 8'd0) gclamp = 8'd1;
    if (gclamp == 8'd255) gclamp = 8'd254;
    gstart = gclamp + 8'd1;
  end

  always_comb begin
    open_bit = (pipe_op_q == OP_RESTORE) ? restore_q : matrix_q[pipe_idx_q[5:0]];
    smp = rd_key;
    if (smp.deb != 8'd0) smp.deb = smp.deb - 8'd1;
    if (open_bit) begin
      if (smp.deb == 8'd0) begin
        smp.status = 8'd0;
        smp.sent   = 1'b0;
      end
    end else if (smp.status == 8'd0) begin
      smp.status = gstart;
      smp.deb    = debounce_ticks_i;
    end
  end

  // queue with the entry at the current count removed
  always_comb begin
    for (int j = 0; j < REPORT_SLOTS; j++) begin
      sh_code[j] = slot_code_q[j];
      sh_ix[j]   = slot_ix_q[j];
      if (j < REPORT_SLOTS - 1 && IW'(j) >= cidx) begin
        sh_code[j] = slot_code_q[j+1];
        sh_ix[j]   = slot_ix_q[j+1];
      end
    end
    sh_code[REPORT_SLOTS-1] = 8'h00;
  end

  assign sts_o.cmp_done    = cnt_full || (cur_code == 8'h00);
  assign sts_o.cmp_need_rd = !sts_o.cmp_done && (cur_code >= CodeFirstReal)
                             && (cur_ix < KeyIdxW'(KeyCount));
  assign sts_o.cmp_ix      = cur_ix;
  assign sts_o.out_free    = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    wr_en       = 1'b0;
    wr_key      = rd_key;
    mod_d       = mod_q;
    row_pop_d   = row_pop_q;
    col_pop_d   = col_pop_q;
    count_d     = count_q;
    slot_code_d = slot_code_q;
    slot_ix_d   = slot_ix_q;
    locked_d    = locked_q;
    rm_d        = rm_q;
    modsum_d    = modsum_q;
    ovf_d       = ovf_q;
    rsp_valid_d = rsp_valid_q;
    rsp_mod_d   = rsp_mod_q;
    rsp_slot_d  = rsp_slot_q;

    if (cmd_i.scan_start) begin
      mod_d = 8'h00;
      for (int i = 0; i < 8; i++) begin
        row_pop_d[i] = 2'd0;
        col_pop_d[i] = 2'd0;
      end
    end
    if (cmd_i.rpt_start) begin
      count_d  = '0;
      locked_d = 1'b0;
      modsum_d = 8'h00;
      ovf_d    = 1'b0;
    end
    if (cmd_i.cmp_step) begin
      if (cur_code < CodeFirstReal) begin
        count_d = count_q + 1'b1;
      end else begin
        slot_code_d = sh_code;
        slot_ix_d   = sh_ix;
      end
    end

    if (pipe_vld_q) begin
      unique case (pipe_op_q)
        OP_SAMPLE: begin
          if (in_region) begin
            wr_en  = 1'b1;
            wr_key = smp;
            if (smp.status == 8'd1) mod_d = mod_q | km;
            if (smp.status != 8'd0) begin
              row_pop_d[row] = row_pop_q[row][1] ? 2'd2 : row_pop_q[row] + 2'd1;
              col_pop_d[col] = col_pop_q[col][1] ? 2'd2 : col_pop_q[col] + 2'd1;
            end
          end
        end
        OP_RESTORE: begin
          wr_en  = 1'b1;
          wr_key = smp;
          if (smp.status > 8'd1) begin
            wr_key.status = 8'd1;
            wr_key.capmod = mod_q;
          end
        end
        OP_GHOST: begin
          if (in_region && rd_key.status > 8'd1) begin
            wr_en = 1'b1;
            if (row_pop_q[row][1] && col_pop_q[col][1]) begin
              if (rd_key.deb != 8'd0) wr_key.status = gstart;
              else if (rd_key.status > 8'd2) wr_key.status = rd_key.status - 8'd1;
            end else begin
              wr_key.status = rd_key.status - 8'd1;
              if (rd_key.status == 8'd2) wr_key.capmod = mod_q;
            end
          end
        end
        OP_CHECK: begin
          if (rd_key.status == 8'd1) begin
            count_d = count_q + 1'b1;
          end else begin
            slot_code_d = sh_code;
            slot_ix_d   = sh_ix;
          end
        end
        OP_REPORT: begin
          if (!ovf_q && rd_key.status == 8'd1) begin
            modsum_d = modsum_q | km;
            if (!rd_key.sent) begin
              if (km != 8'h00) begin
                rm_d        = rm_q | km;
                locked_d    = 1'b1;
                wr_en       = 1'b1;
                wr_key.sent = 1'b1;
              end else if (cnt_full) begin
                ovf_d = 1'b1;
              end else if (!locked_q || rm_q == rd_key.capmod) begin
                rm_d              = xl.modb;
                locked_d          = 1'b1;
                slot_code_d[cidx] = xl.code;
                slot_ix_d[cidx]   = pipe_idx_q;
                wr_en             = 1'b1;
                wr_key.sent       = 1'b1;
                count_d           = count_q + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    if (cmd_i.load) begin
      rsp_valid_d = 1'b1;
      if (ovf_q) begin
        rsp_mod_d = rm_q;
        for (int j = 0; j < OutSlots; j++) rsp_slot_d[j] = CodeRollover;
      end else begin
        if (count_q == '0) rm_d = modsum_q;
        rsp_mod_d = (count_q == '0) ? modsum_q : rm_q;
        for (int j = 0; j < OutSlots; j++) begin
          rsp_slot_d[j] = (j < REPORT_SLOTS) ? slot_code_q[j] : 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q  <= 1'b0;
      pipe_op_q   <= OP_SAMPLE;
      pipe_idx_q  <= '0;
      kvalid_q    <= '0;
      mod_q       <= 8'h00;
      count_q     <= '0;
      locked_q    <= 1'b0;
      rm_q        <= 8'h00;
      modsum_q    <= 8'h00;
      ovf_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        row_pop_q[i] <= 2'd0;
        col_pop_q[i] <= 2'd0;
      end
      for (int j = 0; j < REPORT_SLOTS; j++) begin
        slot_code_q[j] <= 8'h00;
        slot_ix_q[j]   <= '0;
      end
    end else begin
      pipe_vld_q  <= cmd_i.issue;
      pipe_op_q   <= cmd_i.op;
      pipe_idx_q  <= cmd_i.idx;
      if (wr_en) kvalid_q[pipe_idx_q] <= 1'b1;
      mod_q       <= mod_d;
      count_q     <= count_d;
      locked_q    <= locked_d;
      rm_q        <= rm_d;
      modsum_q    <= modsum_d;
      ovf_q       <= ovf_d;
      rsp_valid_q <= rsp_valid_d;
      row_pop_q   <= row_pop_d;
      col_pop_q   <= col_pop_d;
      slot_code_q <= slot_code_d;
      slot_ix_q   <= slot_ix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      matrix_q  <= matrix_open_i;
      restore_q <= restore_open_i;
    end
    rsp_mod_q  <= rsp_mod_d;
    rsp_slot_q <= rsp_slot_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_mod_o   = rsp_mod_q;
  assign rsp_slot_o  = rsp_slot_q;

  // a key is never read back in the cycle it is written
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && cmd_i.issue) |-> (cmd_i.idx != pipe_idx_q))
    else $error("key ram read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(REPORT_SLOTS))
    else $error("slot count beyond queue depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!rsp_valid_q || rsp_ready_i))
    else $error("report overwrote a pending beat");

  a_ovf_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !cmd_i.rpt_start) |=> ovf_q)
    else $error("overflow flag dropped within a report");
endmodule

[rtl/key_matrix_debounce_ghost_hid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_ghost_hid
// Key matrix scanner with debounce, ghost suppression and a HID report queue.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    action, matrix_open, restore_open
//   rsp_o    out  valid/ready    modifier_bits, key_slot_0..key_slot_5
//   apb      in   psel/penable   ghost_ticks @0x0, debounce_ticks @0x4
//
// scan beat: a walk over all 65 entries of the key state ram, then a ghost
// walk over its 64 matrix entries (one read and at most one write per cycle)
// and a drain state; gives no response. report beat: a check of the queued
// slots, a walk over all 65 keys, a drain state, then the response load.
// req_i is ready only while the sequencer is idle; a pending response does
// not block scans, a report waits at its end for the response register.
// reset is asynchronous; key state ram needs no clearing, per-entry valid
// flops make unwritten entries read as released.
// ----------------------------------------------------------------------------
module key_matrix_debounce_ghost_hid
  import kmdg_pkg::*;
#(
  parameter int unsigned MATRIX_ROWS  = DefMatrixRows,
  parameter int unsigned MATRIX_COLS  = DefMatrixCols,
  parameter int unsigned REPORT_SLOTS = DefReportSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kmdg_req_if.sink    req_i,
  kmdg_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0] ghost_ticks_q;
  logic [7:0] debounce_ticks_q;
  logic       cfg_we;

  kmdg_cmd_t                cmd;
  kmdg_sts_t                sts;
  logic [OutSlots-1:0][7:0] slots;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegDebounceTicks) ? {24'h0, debounce_ticks_q}
                                                 : {24'h0, ghost_ticks_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghost_ticks_q    <= GhostTicksRst;
      debounce_ticks_q <= DebounceTicksRst;
    end else if (cfg_we) begin
      if (paddr[2] == RegGhostTicks) ghost_ticks_q <= pwdata[7:0];
      else                           debounce_ticks_q <= pwdata[7:0];
    end
  end

  kmdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.action),
    .in_ready_o  (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kmdg_datapath #(
    .MATRIX_ROWS  (MATRIX_ROWS),
    .MATRIX_COLS  (MATRIX_COLS),
    .REPORT_SLOTS (REPORT_SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .matrix_open_i    (req_i.matrix_open),
    .restore_open_i   (req_i.restore_open),
    .ghost_ticks_i    (ghost_ticks_q),
    .debounce_ticks_i (debounce_ticks_q),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_mod_o        (rsp_o.modifier_bits),
    .rsp_slot_o       (slots)
  );

  assign rsp_o.key_slot_0 = slots[0];
  assign rsp_o.key_slot_1 = slots[1];
  assign rsp_o.key_slot_2 = slots[2];
  assign rsp_o.key_slot_3 = slots[3];
  assign rsp_o.key_slot_4 = slots[4];
  assign rsp_o.key_slot_5 = slots[5];
endmodule

[verif/tb_key_matrix_debounce_ghost_hid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_matrix_debounce_ghost_hid
// Drives scan and report beats into the key matrix scanner and checks every
// HID report against an in-bench model of debounce, ghosting and rollover.
// Runs several register settings, including the extremes, with randomized
// sender gaps, receiver stalls, one long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_key_matrix_debounce_ghost_hid;
  import kmdg_pkg::*;

  localparam logic ActScan   = 1'b0;
  localparam logic ActReport = 1'b1;
  localparam int   NumKeys   = 65;
  localparam int   NumSlots  = 6;

  typedef logic [6:0][7:0] hid_report_t;  // [0] modifier byte, [1..6] slots

  localparam logic [7:0] HidCode [NumKeys] = '{
    8'h1E, 8'h2A, 8'hE0, 8'h48, 8'h2C, 8'hE2, 8'h14, 8'h1F,
    8'h20, 8'h1A, 8'h04, 8'hE1, 8'h1D, 8'h16, 8'h08, 8'h21,
    8'h22, 8'h15, 8'h07, 8'h1B, 8'h06, 8'h09, 8'h17, 8'h23,
    8'h24, 8'h1C, 8'h0A, 8'h19, 8'h05, 8'h0B, 8'h18, 8'h25,
    8'h26, 8'h0C, 8'h0D, 8'h11, 8'h10, 8'h0E, 8'h12, 8'h27,
    8'h2E, 8'h13, 8'h0F, 8'h36, 8'h37, 8'h33, 8'h2F, 8'h2D,
    8'h35, 8'h30, 8'h34, 8'h38, 8'hE5, 8'h4E, 8'h4B, 8'h4A,
    8'h4C, 8'h28, 8'h4F, 8'h51, 8'h3A, 8'h3C, 8'h3E, 8'h40,
    8'h31
  };

  class hid_report_scoreboard;
    logic [7:0] ghost_ticks;
    logic [7:0] debounce_ticks;
    logic [7:0] status [NumKeys];
    logic [7:0] deb    [NumKeys];
    logic       sent   [NumKeys];
    logic [7:0] capmod [NumKeys];
    logic [7:0] slot_code [NumSlots];
    logic [6:0] slot_ix   [NumSlots];
    logic [7:0] rep_mod;
    hid_report_t reports_due[$];
    int errors;

    function new();
      ghost_ticks    = GhostTicksRst;
      debounce_ticks = DebounceTicksRst;
      foreach (status[k]) begin
        status[k] = '0; deb[k] = '0; sent[k] = 1'b0; capmod[k] = '0;
      end
      foreach (slot_code[j]) begin
        slot_code[j] = '0; slot_ix[j] = '0;
      end
      rep_mod = '0;
      errors  = 0;
    endfunction

    function logic [7:0] mod_of_key(int k);
      logic [7:0] c;
      c = HidCode[k];
      if (c[7:3] == 5'b11100) return 8'h01 << c[2:0];
      return 8'h00;
    endfunction

    function logic [7:0] ghost_load();
      logic [7:0] g;
      g = ghost_ticks;
      if (g < 8'd1) g = 8'd1;
      if (g > 8'd254) g = 8'd254;
      return g + 8'd1;
    endfunction

    function void sample_key(int k, logic open);
      if (deb[k] != 0) deb[k]--;
      if (open) begin
        if (deb[k] == 0) begin
          status[k] = '0;
          sent[k]   = 1'b0;
        end
      end else if (status[k] == 0) begin
        status[k] = ghost_load();
        deb[k]    = debounce_ticks;
      end
    endfunction

    function logic [7:0] xlat(int k, inout logic [7:0] m);
      logic [7:0] code;
      code = HidCode[k];
      if ((m & ModShift) != 0) begin
        case (k)
          1:  begin m &= ~ModShift; code = 8'h29; end
          7:  code = 8'h34;
          23: code = 8'h24;
          24: begin m &= ~ModShift; code = 8'h34; end
          31: code = 8'h26;
          32: code = 8'h27;
          39: begin m &= ~ModShift; code = 8'h45; end
          40: begin m &= ~ModShift; code = 8'h4B; end
          45: begin m &= ~ModShift; code = 8'h2F; end
          47: begin m &= ~ModShift; code = 8'h4E; end
          48: code = 8'h2D;
          50: begin m &= ~ModShift; code = 8'h30; end
          54: code = 8'h35;
          55: begin m &= ~ModShift; code = 8'h4D; end
          56: begin m &= ~ModShift; code = 8'h49; end
          58: begin m &= ~ModShift; code = 8'h50; end
          59: begin m &= ~ModShift; code = 8'h52; end
          60: begin m &= ~ModShift; code = 8'h3B; end
          61: begin m &= ~ModShift; code = 8'h3D; end
          62: begin m &= ~ModShift; code = 8'h3F; end
          63: begin m &= ~ModShift; code = 8'h41; end
          default: ;
        endcase
      end else begin
        case (k)
          40: m |= ModLshift;
          45: begin m |= ModLshift; code = 8'h33; end
          46: begin m |= ModLshift; code = 8'h1F; end
          49: begin m |= ModLshift; code = 8'h25; end
          50: code = 8'h33;
          54: begin m |= ModLshift; code = 8'h23; end
          default: ;
        endcase
      end
      if ((m & ModCtrl) != 0 && (k == 45 || k == 46)) begin
        m &= ~ModShift;
        code = 8'h2F;
      end
      if (k == 53) begin
        code = 8'h2E;
        m &= ~ModShift;
      end
      return code;
    endfunction

    function void scan(logic [63:0] mat, logic restore_open);
      int col_pop [8];
      int row_pop [8];
      logic [7:0] held_mod;
      int k;
      held_mod = '0;
      foreach (col_pop[i]) begin
        col_pop[i] = 0; row_pop[i] = 0;
      end
      for (int r = 0; r < 8; r++)
        for (int c = 0; c < 8; c++) begin
          k = r * 8 + c;
          sample_key(k, mat[k]);
          if (status[k] == 1) held_mod |= mod_of_key(k);
          if (status[k] != 0) begin
            col_pop[c]++;
            row_pop[r]++;
          end
        end
      // restore key is outside the matrix: never ghosted, settles at once
      sample_key(RestoreKey, restore_open);
      if (status[RestoreKey] > 1) begin
        status[RestoreKey] = 8'd1;
        capmod[RestoreKey] = held_mod;
      end
      for (int r = 0; r < 8; r++)
        for (int c = 0; c < 8; c++) begin
          k = r * 8 + c;
          if (status[k] <= 1) continue;
          if (col_pop[c] > 1 && row_pop[r] > 1) begin
            if (deb[k] != 0) status[k] = ghost_load();
            else if (status[k] > 2) status[k]--;
          end else begin
            status[k]--;
            if (status[k] == 1) capmod[k] = held_mod;
          end
        end
    endfunction

    function hid_report_t report();
      hid_report_t rpt;
      int count;
      logic locked;
      logic [7:0] km;
      count  = 0;
      locked = 1'b0;
      while (count < NumSlots) begin
        if (slot_code[count] == 0) break;
        if (slot_code[count] >= CodeFirstReal &&
            (slot_ix[count] >= NumKeys || status[slot_ix[count]] != 1)) begin
          for (int j = count; j + 1 < NumSlots; j++) begin
            slot_code[j] = slot_code[j+1];
            slot_ix[j]   = slot_ix[j+1];
          end
          slot_code[NumSlots-1] = '0;
          continue;
        end
        count++;
      end
      for (int k = 0; k < NumKeys; k++) begin
        if (status[k] != 1 || sent[k]) continue;
        km = mod_of_key(k);
        if (km != 0) begin
          rep_mod |= km;
          locked  = 1'b1;
          sent[k] = 1'b1;
        end else begin
          if (count >= NumSlots) begin
            rpt[0] = rep_mod;
            for (int j = 1; j <= NumSlots; j++) rpt[j] = CodeRollover;
            return rpt;
          end
          if (!locked || rep_mod == capmod[k]) begin
            rep_mod          = capmod[k];
            locked           = 1'b1;
            slot_ix[count]   = k[6:0];
            slot_code[count] = xlat(k, rep_mod);
            sent[k]          = 1'b1;
            count++;
          end
        end
      end
      if (count == 0) begin
        rep_mod = '0;
        for (int k = 0; k < NumKeys; k++)
          if (status[k] == 1) rep_mod |= mod_of_key(k);
      end
      rpt[0] = rep_mod;
      for (int j = 0; j < NumSlots; j++) rpt[j+1] = slot_code[j];
      return rpt;
    endfunction

    function void note_beat(logic act, logic [63:0] mat, logic restore_open);
      if (act == ActScan) scan(mat, restore_open);
      else reports_due.push_back(report());
    endfunction

    function void check_report(hid_report_t got);
      hid_report_t exp_rpt;
      if (reports_due.size() == 0) begin
        $display("%0t unexpected report: expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_rpt = reports_due.pop_front();
      for (int i = 0; i < 7; i++)
        if (got[i] !== exp_rpt[i]) begin
          $display("%0t report field %0d mismatch: expected %02h actual %02h",
                   $time, i, exp_rpt[i], got[i]);
          errors++;
        end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kmdg_req_if req ();
  kmdg_rsp_if rsp ();

  key_matrix_debounce_ghost_hid dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hid_report_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[key_matrix_debounce_ghost_hid] ERROR");
    $finish;
  end

  // receiver: random stalls, plus a counted hold-off when requested
  initial rsp.ready = 1'b0;
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ready and valid are stable mid-cycle, the beat lands on the next edge
  always @(negedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready)
      sb.check_report({rsp.key_slot_5, rsp.key_slot_4, rsp.key_slot_3, rsp.key_slot_2,
                       rsp.key_slot_1, rsp.key_slot_0, rsp.modifier_bits});
  end

  task automatic send_beat(input logic act, input logic [63:0] mat, input logic ropen);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.matrix_open  <= mat;
    req.restore_open <= ropen;
    @(negedge clk_i);
    while (!req.ready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_beat(act, mat, ropen);
  endtask

  task automatic drain_reports();
    req.valid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    drain_reports();
    repeat (150) @(posedge clk_i);  // a scan gives no response, let it finish
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegGhostTicks) sb.ghost_ticks = value;
    else sb.debounce_ticks = value;
  endtask

  task automatic hold_keys(input logic [63:0] mat, input logic ropen, input int scans);
    repeat (scans) send_beat(ActScan, mat, ropen);
  endtask

  // a press session: a few keys held steady for a while, reports sprinkled in; or a lone random scan
  task automatic key_session(output int beats);
    logic [63:0] mat;
    logic ropen;
    int nkeys;
    int scans;
    beats = 0;
    if ($urandom_range(9) == 0) begin
      send_beat(ActScan, {$urandom, $urandom}, 1'($urandom_range(1)));
      beats = 1;
      return;
    end
    mat   = '1;
    ropen = ($urandom_range(9) != 0);
    nkeys = $urandom_range(8);
    repeat (nkeys) begin
      if ($urandom_range(3) == 0) mat[($urandom_range(1) == 1) ? 11 : 2] = 1'b0;
      else mat[$urandom_range(63)] = 1'b0;
    end
    scans = $urandom_range(1, 6);
    if (sb.ghost_ticks < 8'd12) scans += sb.ghost_ticks;
    repeat (scans) begin
      send_beat(ActScan, mat, ropen);
      beats++;
      if ($urandom_range(3) == 0) begin
        send_beat(ActReport, {$urandom, $urandom}, 1'($urandom_range(1)));
        beats++;
      end
    end
    send_beat(ActReport, mat, ropen);
    beats++;
  endtask

  task automatic run_phase(input int items, input int idle, input int stall);
    int done;
    int n;
    idle_pct  = idle;
    stall_pct = stall;
    done = 0;
    while (done < items) begin
      key_session(n);
      done += n;
    end
  endtask

  initial begin
    logic [63:0] diag;
    sb          = new();
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    req.valid        = 1'b0;
    req.action       = ActScan;
    req.matrix_open  = '1;
    req.restore_open = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty report, all open, all pressed, restore key
    send_beat(ActReport, '1, 1'b1);
    send_beat(ActScan, '1, 1'b1);
    send_beat(ActScan, '0, 1'b0);
    send_beat(ActReport, '0, 1'b0);
    send_beat(ActScan, '1, 1'b1);
    write_reg(RegGhostTicks, 8'd1);
    write_reg(RegDebounceTicks, 8'd0);
    hold_keys(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 3);
    send_beat(ActReport, '1, 1'b1);
    // shift with a shift-overridden key, then ctrl with a ctrl-overridden key
    hold_keys(~((64'd1 << 11) | (64'd1 << 1)), 1'b1, 3);
    send_beat(ActReport, '1, 1'b1);
    hold_keys(~((64'd1 << 2) | (64'd1 << 45)), 1'b1, 3);
    send_beat(ActReport, '1, 1'b1);
    // seven regular keys on distinct rows and columns, plus the restore key: rollover
    diag = '1;
    for (int r = 0; r < 7; r++) diag[r * 9] = 1'b0;
    hold_keys(diag, 1'b0, 3);
    send_beat(ActReport, '1, 1'b1);
    send_beat(ActReport, '1, 1'b1);
    hold_keys('1, 1'b1, 2);
    send_beat(ActReport, '1, 1'b1);

    run_phase(120, 0, 0);
    write_reg(RegGhostTicks, 8'd3);
    write_reg(RegDebounceTicks, 8'd5);
    run_phase(100, 84, 0);
    write_reg(RegGhostTicks, 8'd0);
    write_reg(RegDebounceTicks, 8'd1);
    run_phase(100, 0, 84);
    // long receiver hold-off while reports keep coming: input must stall
    hold_cycles = 3000;
    idle_pct = 0;
    repeat (12) send_beat(ActReport, '1, 1'b1);
    drain_reports();
    write_reg(RegGhostTicks, 8'd2);
    write_reg(RegDebounceTicks, 8'd255);
    run_phase(100, 31, 31);
    write_reg(RegGhostTicks, 8'd255);
    write_reg(RegDebounceTicks, 8'd0);
    run_phase(30, 0, 0);
    write_reg(RegGhostTicks, 8'd254);
    write_reg(RegDebounceTicks, 8'd1);
    run_phase(20, 31, 31);
    write_reg(RegGhostTicks, 8'd1);
    write_reg(RegDebounceTicks, 8'd3);
    run_phase(80, 0, 0);
    drain_reports();
    run_phase(80, 84, 84);

    drain_reports();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[key_matrix_debounce_ghost_hid] OK");
    end else begin
      $display("[key_matrix_debounce_ghost_hid] ERROR");
    end
    $finish;
  end

endmodule
